>>> hdl/hjc_pkg.sv
// Shared types, jamo codes and syllable arithmetic for the Hangul syllable composer.
// No dependencies; every other file in hdl/ imports this package.
package hjc_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_EMIT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Character code ranges
    localparam logic [15:0] CH_BACKSPACE = 16'h0008;
    localparam logic [15:0] CH_CONS_LO   = 16'h3131;
    localparam logic [15:0] CH_CONS_HI   = 16'h314E;
    localparam logic [15:0] CH_VOW_LO    = 16'h314F;
    localparam logic [15:0] CH_VOW_HI    = 16'h3163;
    localparam logic [15:0] JAMO_BASE    = 16'h3130;   // jamo held as code minus this
    localparam logic [15:0] SYL_BASE     = 16'hAC00;
    localparam logic [15:0] TAIL_COUNT   = 16'd28;
    localparam logic [15:0] LEAD_STRIDE  = 16'd588;    // 21 vowels * 28 tails
    // Lead slot with no syllable position wraps: 588 * 0xFFFF mod 2^16
    localparam logic [15:0] LEAD_NONE_TERM = 16'(65536 - 588);

    // Jamo offsets (code minus JAMO_BASE); 0 means empty
    localparam logic [5:0] JM_KIYEOK  = 6'h01;
    localparam logic [5:0] JM_KS      = 6'h03;
    localparam logic [5:0] JM_NIEUN   = 6'h04;
    localparam logic [5:0] JM_NJ      = 6'h05;
    localparam logic [5:0] JM_NH      = 6'h06;
    localparam logic [5:0] JM_SSDIG   = 6'h08;
    localparam logic [5:0] JM_RIEUL   = 6'h09;
    localparam logic [5:0] JM_RK      = 6'h0A;
    localparam logic [5:0] JM_RM      = 6'h0B;
    localparam logic [5:0] JM_RB      = 6'h0C;
    localparam logic [5:0] JM_RS      = 6'h0D;
    localparam logic [5:0] JM_RT      = 6'h0E;
    localparam logic [5:0] JM_RP      = 6'h0F;
    localparam logic [5:0] JM_RH      = 6'h10;
    localparam logic [5:0] JM_MIEUM   = 6'h11;
    localparam logic [5:0] JM_PIEUP   = 6'h12;
    localparam logic [5:0] JM_SSBIEUP = 6'h13;
    localparam logic [5:0] JM_BS      = 6'h14;
    localparam logic [5:0] JM_SIOS    = 6'h15;
    localparam logic [5:0] JM_CIEUC   = 6'h18;
    localparam logic [5:0] JM_SSJIEUJ = 6'h19;
    localparam logic [5:0] JM_THIEUTH = 6'h1C;
    localparam logic [5:0] JM_PHIEUPH = 6'h1D;
    localparam logic [5:0] JM_HIEUH   = 6'h1E;
    localparam logic [5:0] JM_A       = 6'h1F;
    localparam logic [5:0] JM_AE      = 6'h20;
    localparam logic [5:0] JM_EO      = 6'h23;
    localparam logic [5:0] JM_E       = 6'h24;
    localparam logic [5:0] JM_O       = 6'h27;
    localparam logic [5:0] JM_WA      = 6'h28;
    localparam logic [5:0] JM_WAE     = 6'h29;
    localparam logic [5:0] JM_OE      = 6'h2A;
    localparam logic [5:0] JM_U       = 6'h2C;
    localparam logic [5:0] JM_WEO     = 6'h2D;
    localparam logic [5:0] JM_WE      = 6'h2E;
    localparam logic [5:0] JM_WI      = 6'h2F;
    localparam logic [5:0] JM_EU      = 6'h31;
    localparam logic [5:0] JM_YI      = 6'h32;
    localparam logic [5:0] JM_I       = 6'h33;

    // Channel payloads
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] char_code;
        logic        notify;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_char;
        logic        composing;
        logic        last;
    } t_out_item;

    // Item class decided by the front end
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_EMIT,
        KIND_CLEAR,
        KIND_BKSP,
        KIND_OTHER,
        KIND_CONS,
        KIND_VOW
    } t_kind;

    // Queue entry between front and back
    typedef struct packed {
        t_kind       kind;
        logic [5:0]  jamo;
        logic [15:0] char_code;
        logic        notify;
    } t_q_entry;

    // Can b follow a in one compound letter
    function automatic logic joinable(input logic [5:0] a, input logic [5:0] b);
        logic ok;
        ok = 1'b0;
        if (a == '0 || b == '0) begin
            ok = 1'b1;
        end else begin
            case (a)
                JM_KIYEOK: ok = (b == JM_SIOS);
                JM_NIEUN:  ok = (b == JM_CIEUC) || (b == JM_HIEUH);
                JM_RIEUL:  ok = (b == JM_KIYEOK) || (b == JM_MIEUM) || (b == JM_PIEUP) ||
                                (b == JM_SIOS) || (b == JM_THIEUTH) || (b == JM_PHIEUPH) ||
                                (b == JM_HIEUH);
                JM_PIEUP:  ok = (b == JM_SIOS);
                JM_O:      ok = (b == JM_A) || (b == JM_AE) || (b == JM_I);
                JM_U:      ok = (b == JM_EO) || (b == JM_E) || (b == JM_I);
                JM_EU:     ok = (b == JM_I);
                default:   ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    // Compound letter of a stored pair
    function automatic logic [5:0] join_pair(input logic [5:0] a, input logic [5:0] b);
        logic [5:0] r;
        r = a;
        if (a == '0) begin
            r = b;
        end else if (b != '0) begin
            case (a)
                JM_KIYEOK: r = JM_KS;
                JM_NIEUN:  r = (b == JM_CIEUC) ? JM_NJ : JM_NH;
                JM_RIEUL: begin
                    case (b)
                        JM_KIYEOK:  r = JM_RK;
                        JM_MIEUM:   r = JM_RM;
                        JM_PIEUP:   r = JM_RB;
                        JM_SIOS:    r = JM_RS;
                        JM_THIEUTH: r = JM_RT;
                        JM_PHIEUPH: r = JM_RP;
                        JM_HIEUH:   r = JM_RH;
                        default:    r = a;
                    endcase
                end
                JM_PIEUP:  r = JM_BS;
                JM_O:      r = (b == JM_A) ? JM_WA : ((b == JM_AE) ? JM_WAE : JM_OE);
                JM_U:      r = (b == JM_EO) ? JM_WEO : ((b == JM_E) ? JM_WE : JM_WI);
                JM_EU:     r = JM_YI;
                default:   r = a;
            endcase
        end
        return r;
    endfunction

    // 588 * lead slot of an initial consonant, mod 2^16
    function automatic logic [15:0] lead_term(input logic [5:0] ofs);
        logic [4:0] slot;
        logic       none;
        slot = '0;
        none = 1'b0;
        case (ofs) inside
            6'd1:          slot = 5'd0;
            6'd2:          slot = 5'd1;
            6'd4:          slot = 5'd2;
            6'd7:          slot = 5'd3;
            6'd8:          slot = 5'd4;
            6'd9:          slot = 5'd5;
            6'd17:         slot = 5'd6;
            6'd18:         slot = 5'd7;
            6'd19:         slot = 5'd8;
            [6'd21:6'd30]: slot = 5'(ofs - 6'd12);
            default:       none = 1'b1;
        endcase
        return none ? LEAD_NONE_TERM : 16'({11'd0, slot} * LEAD_STRIDE);
    endfunction

    // Tail slot plus one of a final consonant; unmappable tails wrap to 0
    function automatic logic [15:0] tail_term(input logic [5:0] ofs);
        logic [5:0] t;
        t = '0;
        case (ofs) inside
            [6'd1:6'd7]:   t = ofs;
            [6'd9:6'd18]:  t = ofs - 6'd1;
            [6'd20:6'd24]: t = ofs - 6'd2;
            [6'd26:6'd30]: t = ofs - 6'd3;
            default:       t = '0;
        endcase
        return {10'd0, t};
    endfunction

    // Character code of a stored jamo, 0 when empty
    function automatic logic [15:0] jamo_code(input logic [5:0] ofs);
        return (ofs == '0) ? 16'd0 : JAMO_BASE + {10'd0, ofs};
    endfunction

    // Character shown for a composition
    function automatic logic [15:0] compose(input logic [5:0] ini, input logic [5:0] m0,
                                            input logic [5:0] m1, input logic [5:0] f0,
                                            input logic [5:0] f1);
        logic [5:0]  m;
        logic [5:0]  f;
        logic [5:0]  mi;
        logic [15:0] v;
        m  = join_pair(m0, m1);
        f  = join_pair(f0, f1);
        mi = m - JM_A;
        v  = SYL_BASE + lead_term(ini) + 16'({10'd0, mi} * TAIL_COUNT);
        if (f != '0) begin
            v = v + tail_term(f);
        end
        if (ini == '0 && m == '0) begin
            v = jamo_code(f);
        end else if (ini == '0) begin
            v = jamo_code(m);
        end else if (m == '0) begin
            v = jamo_code(ini);
        end
        return v;
    endfunction

endpackage

>>> hdl/hjc_front.sv
// Front end of the Hangul syllable composer: classifies input transfers.
// Depends on hjc_pkg; feeds hjc_queue.
module hjc_front (
    input  logic               i_in_valid,
    input  hjc_pkg::t_in_item  i_in_item,
    input  logic               i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output hjc_pkg::t_q_entry  o_entry
);
    import hjc_pkg::*;

    logic is_cons;
    logic is_vow;

    // Stall only on a full queue
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign is_cons = (i_in_item.char_code >= CH_CONS_LO) && (i_in_item.char_code <= CH_CONS_HI);
    assign is_vow  = (i_in_item.char_code >= CH_VOW_LO) && (i_in_item.char_code <= CH_VOW_HI);

    // Classify command and character
    always_comb begin
        o_entry.char_code = i_in_item.char_code;
        o_entry.notify    = i_in_item.notify;
        o_entry.jamo      = 6'(i_in_item.char_code - JAMO_BASE);
        unique case (i_in_item.cmd)
            CMD_EMIT:  o_entry.kind = KIND_EMIT;
            CMD_CLEAR: o_entry.kind = KIND_CLEAR;
            CMD_ADD: begin
                if (i_in_item.char_code == CH_BACKSPACE) begin
                    o_entry.kind = KIND_BKSP;
                end else if (is_cons) begin
                    o_entry.kind = KIND_CONS;
                end else if (is_vow) begin
                    o_entry.kind = KIND_VOW;
                end else begin
                    o_entry.kind = KIND_OTHER;
                end
            end
            default:   o_entry.kind = KIND_NOP;
        endcase
    end

endmodule

>>> hdl/hjc_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on hjc_pkg for the entry type.
module hjc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hjc_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output hjc_pkg::t_q_entry  o_entry
);
    import hjc_pkg::*;

    t_q_entry   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> hdl/hjc_exec.sv
// Back end: holds the composition, applies one queued item per transfer and
// buffers its up to two results. Depends on hjc_pkg.
module hjc_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  hjc_pkg::t_q_entry   i_entry,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hjc_pkg::t_out_item  o_out_item
);
    import hjc_pkg::*;

    // Composition state, jamo offsets
    logic [5:0]  r_ini, r_med0, r_med1, r_fin0, r_fin1;
    logic [5:0]  n_ini, n_med0, n_med1, n_fin0, n_fin1;
    // Result buffer: head drives the port, second waits behind it
    logic        r_h_vld, r_s_vld;
    t_out_item   r_h, r_s;

    logic [15:0] old_comp;
    logic [15:0] mv_comp;
    logic [15:0] new_comp;
    logic [15:0] cand_a, cand_b;
    logic [15:0] cand_b_pre;
    logic        en_a, en_b, comp_b;
    logic        va, vb;
    logic        take;
    logic        pop;
    logic [5:0]  c;
    logic        tail_ok;
    logic        mv_two;

    assign c        = i_entry.jamo;
    assign tail_ok  = (c != JM_SSDIG) && (c != JM_SSBIEUP) && (c != JM_SSJIEUJ);
    assign mv_two   = (r_fin1 != '0);
    assign old_comp = compose(r_ini, r_med0, r_med1, r_fin0, r_fin1);
    // Composition left when a vowel takes the last final away
    assign mv_comp  = compose(r_ini, r_med0, r_med1, mv_two ? r_fin0 : 6'd0, 6'd0);
    assign new_comp = compose(n_ini, n_med0, n_med1, n_fin0, n_fin1);

    assign take    = r_h_vld && !i_out_stall;
    assign pop     = i_q_valid && (!r_h_vld || (take && !r_s_vld));
    assign o_q_pop = pop;

    // Next composition and result candidates
    always_comb begin
        n_ini      = r_ini;
        n_med0     = r_med0;
        n_med1     = r_med1;
        n_fin0     = r_fin0;
        n_fin1     = r_fin1;
        cand_a     = '0;
        cand_b_pre = '0;
        en_a       = 1'b0;
        en_b       = 1'b0;
        comp_b     = 1'b0;
        unique case (i_entry.kind)
            KIND_EMIT: begin
                cand_a = old_comp;
                en_a   = 1'b1;
                {n_ini, n_med0, n_med1, n_fin0, n_fin1} = '0;
            end
            KIND_CLEAR: begin
                {n_ini, n_med0, n_med1, n_fin0, n_fin1} = '0;
            end
            KIND_BKSP: begin
                if (r_fin1 != '0) begin
                    n_fin1 = '0;
                end else if (r_fin0 != '0) begin
                    n_fin0 = '0;
                end else if (r_med1 != '0) begin
                    n_med1 = '0;
                end else if (r_med0 != '0) begin
                    n_med0 = '0;
                end else if (r_ini != '0) begin
                    n_ini = '0;
                end else begin
                    cand_a = i_entry.char_code;
                    en_a   = 1'b1;
                end
            end
            KIND_OTHER: begin
                cand_a     = old_comp;
                en_a       = 1'b1;
                cand_b_pre = i_entry.char_code;
                en_b       = 1'b1;
                {n_ini, n_med0, n_med1, n_fin0, n_fin1} = '0;
            end
            KIND_CONS: begin
                if (r_ini != '0 && r_med0 == '0 && joinable(r_ini, c)) begin
                    // Initial and new consonant form a compound final
                    n_fin0 = r_ini;
                    n_fin1 = c;
                    n_ini  = '0;
                end else if (r_ini == '0 || r_med0 == '0 || !tail_ok || r_fin1 != '0 ||
                             !joinable(r_fin0, c)) begin
                    cand_a = old_comp;
                    {n_ini, n_med0, n_med1, n_fin0, n_fin1} = '0;
                    n_ini  = c;
                end else if (r_fin0 == '0) begin
                    n_fin0 = c;
                end else begin
                    n_fin1 = c;
                end
                en_a   = i_entry.notify;
                en_b   = i_entry.notify;
                comp_b = 1'b1;
            end
            KIND_VOW: begin
                if (r_fin0 != '0) begin
                    // Last final moves over to start the next syllable
                    cand_a = mv_comp;
                    {n_ini, n_med0, n_med1, n_fin0, n_fin1} = '0;
                    n_ini  = mv_two ? r_fin1 : r_fin0;
                    n_med0 = c;
                end else if (r_med1 != '0 || !joinable(r_med0, c)) begin
                    cand_a = old_comp;
                    {n_ini, n_med0, n_med1, n_fin0, n_fin1} = '0;
                    n_med0 = c;
                end else if (r_med0 == '0) begin
                    n_med0 = c;
                end else begin
                    n_med1 = c;
                end
                en_a   = i_entry.notify;
                en_b   = i_entry.notify;
                comp_b = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Live composition goes out as the second result of a jamo
    assign cand_b = comp_b ? new_comp : cand_b_pre;

    // Code zero is never sent
    assign va = en_a && (cand_a != '0);
    assign vb = en_b && (cand_b != '0);

    // Control state and composition
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_ini   <= '0;
            r_med0  <= '0;
            r_med1  <= '0;
            r_fin0  <= '0;
            r_fin1  <= '0;
        end else begin
            if (pop) begin
                r_h_vld <= va || vb;
                r_s_vld <= va && vb;
                r_ini   <= n_ini;
                r_med0  <= n_med0;
                r_med1  <= n_med1;
                r_fin0  <= n_fin0;
                r_fin1  <= n_fin1;
            end else if (take) begin
                r_h_vld <= r_s_vld;
                r_s_vld <= 1'b0;
            end
        end
    end

    // Result payloads
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (va) begin
                r_h <= '{out_char: cand_a, composing: 1'b0, last: !vb};
            end else begin
                r_h <= '{out_char: cand_b, composing: comp_b, last: 1'b1};
            end
            r_s <= '{out_char: cand_b, composing: comp_b, last: 1'b1};
        end else if (take) begin
            r_h <= r_s;
        end
    end

    assign o_out_valid = r_h_vld;
    assign o_out_item  = r_h;

endmodule

>>> hdl/hangul_jamo_syllable_composer_top.sv
// Top level of the Hangul syllable composer: front classifier, queue, back end.
// Depends on hjc_pkg, hjc_front, hjc_queue and hjc_exec.
//
// Takes one 16-bit character per input transfer and builds Korean syllables
// from compatibility jamo, passing other characters through. An input is taken
// whenever the two-entry queue has room; the back end applies one queued item
// per cycle while its two-deep output buffer has room for the results; it takes
// the next item only once the buffer is empty or its last result is being taken.
// Between input transfer and first result lie the queue and the output buffer
// registers. Output stall never blocks input until the queue fills.
module hangul_jamo_syllable_composer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hjc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hjc_pkg::t_out_item  o_out_item
);
    import hjc_pkg::*;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    t_q_entry q_wr_entry;
    t_q_entry q_rd_entry;

    // Classify and enqueue
    hjc_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_entry    (q_wr_entry)
    );

    hjc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_rd_entry)
    );

    // Apply items and deliver results
    hjc_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_entry     (q_rd_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Nothing is offered right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The live composition always closes an item's results
    a_composing_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.composing |-> o_out_item.last)
        else $error("composing result not marked last");

    // A non-last result is followed at once by the rest of its item
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last && !i_out_stall |=> o_out_valid)
        else $error("second result missing after first transfer");

    // A full queue always has an item for the back end
    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> q_valid)
        else $error("queue full but empty");

endmodule
